>>> design/nprs_pkg.sv
// ----------------------------------------------------------------------------
// nprs_pkg
// Shared types and constants of the nonzero page region segmenter.
// ----------------------------------------------------------------------------
package nprs_pkg;

  localparam int PageIndexBitsDefault = 32;

  localparam int CfgDataBits  = 32;
  localparam int CfgIndexBits = 2;
  localparam int ZeroRunBits  = 16;
  localparam int RangeCntBits = 13;
  localparam int RangeBits    = 32;

  // register indexes on the configuration port
  typedef enum logic [CfgIndexBits-1:0] {
    REG_HOLE_FIRST = 2'd0,
    REG_HOLE_LAST  = 2'd1,
    REG_ZERO_LIMIT = 2'd2,
    REG_MAX_RANGES = 2'd3
  } cfg_reg_t;

  localparam logic [31:0]             HoleFirstReset = 32'h0000_00a0;
  localparam logic [31:0]             HoleLastReset  = 32'h0000_00bf;
  localparam logic [ZeroRunBits-1:0]  ZeroLimitReset = 16'd128;
  localparam logic [RangeCntBits-1:0] MaxRangesReset = 13'd64;

  typedef struct packed {
    logic [31:0]             hole_first_page;
    logic [31:0]             hole_last_page;
    logic [ZeroRunBits-1:0]  zero_run_limit;
    logic [RangeCntBits-1:0] max_ranges;
  } cfg_t;

  typedef struct packed {
    logic page_zero;
    logic last_page;
  } page_beat_t;

endpackage

>>> design/nprs_cfg.sv
// ----------------------------------------------------------------------------
// nprs_cfg
// Configuration register file: hole bounds, zero run limit, table capacity.
// ----------------------------------------------------------------------------
module nprs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nprs_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [nprs_pkg::CfgDataBits-1:0]    cfg_wdata,
  output nprs_pkg::cfg_t                      cfg
);
  import nprs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hole_first_page <= HoleFirstReset;
      cfg_r.hole_last_page  <= HoleLastReset;
      cfg_r.zero_run_limit  <= ZeroLimitReset;
      cfg_r.max_ranges      <= MaxRangesReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HOLE_FIRST: cfg_r.hole_first_page <= cfg_wdata;
        REG_HOLE_LAST:  cfg_r.hole_last_page  <= cfg_wdata;
        REG_ZERO_LIMIT: cfg_r.zero_run_limit  <= cfg_wdata[ZeroRunBits-1:0];
        REG_MAX_RANGES: cfg_r.max_ranges      <= cfg_wdata[RangeCntBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/nprs_in_stage.sv
// ----------------------------------------------------------------------------
// nprs_in_stage
// Input register: captures one page beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module nprs_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 page_zero,
  input  logic                 last_page,
  input  logic                 advance,
  output logic                 s1_valid,
  output nprs_pkg::page_beat_t s1_beat
);
  import nprs_pkg::*;

  logic       valid_r;
  page_beat_t beat_r;

  // take a new beat when the register is empty or the held one leaves this cycle
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_r.page_zero <= page_zero;
      beat_r.last_page <= last_page;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

>>> design/nprs_core.sv
// ----------------------------------------------------------------------------
// nprs_core
// Region tracking state, per-page update and the result register.
// ----------------------------------------------------------------------------
module nprs_core #(
  parameter int PAGE_INDEX_BITS = nprs_pkg::PageIndexBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nprs_pkg::cfg_t                      cfg,
  input  logic                                s1_valid,
  input  nprs_pkg::page_beat_t                s1_beat,
  output logic                                advance,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nprs_pkg::RangeBits-1:0]      range_start,
  output logic [nprs_pkg::RangeBits-1:0]      range_pages,
  output logic                                table_full,
  output logic                                scan_done
);
  import nprs_pkg::*;

  localparam int CmpW = (PAGE_INDEX_BITS > 32) ? PAGE_INDEX_BITS : 32;

  logic [PAGE_INDEX_BITS-1:0] page_cnt_r, page_cnt_nxt;
  logic [PAGE_INDEX_BITS-1:0] first_r, first_nxt;
  logic [PAGE_INDEX_BITS-1:0] last_nz_r, last_nz_nxt;
  logic [ZeroRunBits-1:0]     zero_run_r, zero_run_nxt;
  logic [RangeCntBits-1:0]    used_r, used_nxt;
  logic                       open_r, open_nxt;
  logic                       ovf_r, ovf_nxt;

  logic                       out_valid_r;
  logic [RangeBits-1:0]       start_r, pages_r;
  logic                       full_r, done_r;

  logic [CmpW-1:0]            pg_ext, first_ext, diff_ext;
  logic                       in_hole, is_zero, emit, full;
  logic [ZeroRunBits-1:0]     zero_run_inc;

  // hold the stage while a result waits and the receiver stalls
  assign advance = !out_valid_r || out_tready;

  always_comb begin
    pg_ext       = CmpW'(page_cnt_r);
    in_hole      = (pg_ext >= CmpW'(cfg.hole_first_page)) &&
                   (pg_ext <= CmpW'(cfg.hole_last_page));
    is_zero      = in_hole || s1_beat.page_zero;
    zero_run_inc = (zero_run_r != {ZeroRunBits{1'b1}}) ? zero_run_r + 1'b1 : zero_run_r;

    page_cnt_nxt = page_cnt_r + 1'b1;
    first_nxt    = first_r;
    last_nz_nxt  = last_nz_r;
    zero_run_nxt = zero_run_r;
    open_nxt     = open_r;
    emit         = 1'b0;

    if (open_r) begin
      if (is_zero) begin
        zero_run_nxt = zero_run_inc;
      end else begin
        last_nz_nxt  = page_cnt_r;
        zero_run_nxt = '0;
      end
      if ((zero_run_nxt >= cfg.zero_run_limit) || in_hole || s1_beat.last_page) begin
        open_nxt     = 1'b0;
        zero_run_nxt = '0;
        emit         = 1'b1;
      end
    end else if (!is_zero) begin
      zero_run_nxt = '0;
      first_nxt    = page_cnt_r;
      last_nz_nxt  = page_cnt_r;
      open_nxt     = !s1_beat.last_page;
      emit         = s1_beat.last_page;
    end

    full      = used_r >= cfg.max_ranges;
    used_nxt  = (emit && !full) ? used_r + 1'b1 : used_r;
    ovf_nxt   = emit && full;
    first_ext = CmpW'(first_nxt);
    diff_ext  = CmpW'(last_nz_nxt) - first_ext + CmpW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_cnt_r <= '0;
      first_r    <= '0;
      last_nz_r  <= '0;
      zero_run_r <= '0;
      used_r     <= '0;
      open_r     <= 1'b1;
      ovf_r      <= 1'b0;
    end else if (s1_valid && advance && !ovf_r) begin
      page_cnt_r <= page_cnt_nxt;
      first_r    <= first_nxt;
      last_nz_r  <= last_nz_nxt;
      zero_run_r <= zero_run_nxt;
      used_r     <= used_nxt;
      open_r     <= open_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid && !ovf_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && !ovf_r && emit) begin
      start_r <= first_ext[RangeBits-1:0];
      pages_r <= diff_ext[RangeBits-1:0];
      full_r  <= full;
      done_r  <= s1_beat.last_page;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign range_start = start_r;
  assign range_pages = pages_r;
  assign table_full  = full_r;
  assign scan_done   = done_r;

endmodule

>>> design/nonzero_page_region_segmenter.sv
// ----------------------------------------------------------------------------
// nonzero_page_region_segmenter
// Splits a stream of page zero flags into regions of nonzero pages.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per page, in page order; in_tdata[0] is the all-zero
//           flag, in_tlast marks the final page. The page index is counted
//           inside, from 0.
//   out_* : one beat per closed region: start page and length in tdata,
//           out_tuser set when the range table was full, out_tlast set when
//           the region closes on the final page.
//   cfg_* : register writes; the user must make them only while the block
//           is idle, since the block itself does not enforce it.
// A beat passes the input register and the result register. One page is
// taken every cycle while the receiver does not stall. Reset clears the page
// counter and opens the first region at page 0; the registers return to their
// defaults. When the receiver stalls, the result register holds and one
// further beat is parked in the input register before in_tready drops. After
// a table overflow, beats are taken and dropped until reset.
// ----------------------------------------------------------------------------
module nonzero_page_region_segmenter #(
  parameter int PAGE_INDEX_BITS = nprs_pkg::PageIndexBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] page_zero, [7:1] zero
  input  logic                              in_tlast,   // last_page
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,  // [31:0] range_start, [63:32] range_pages
  output logic                              out_tuser,  // table_full
  output logic                              out_tlast,  // scan_done
  input  logic                              cfg_we,
  input  logic [nprs_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [nprs_pkg::CfgDataBits-1:0]  cfg_wdata
);
  import nprs_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid;
  page_beat_t           s1_beat;
  logic                 advance;
  logic [RangeBits-1:0] range_start, range_pages;

  nprs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nprs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .page_zero (in_tdata[0]),
    .last_page (in_tlast),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_beat   (s1_beat)
  );

  nprs_core #(
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_beat     (s1_beat),
    .advance     (advance),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .range_start (range_start),
    .range_pages (range_pages),
    .table_full  (out_tuser),
    .scan_done   (out_tlast)
  );

  assign out_tdata = {range_pages, range_start};

endmodule
